[hdl/srsl_pkg.sv]
// Shared types and constants for the sorted run stack lookup core.
// No dependencies.
package srsl_pkg;

   localparam int MAX_RUNS    = 16;
   localparam int STORE_DEPTH = 4096;
   localparam int KEY_W       = 64;

   // entry store address, fill count (holds STORE_DEPTH), run index, run count
   localparam int STORE_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int FILL_W   = $clog2(STORE_DEPTH + 1);
   localparam int RUN_IW   = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
   localparam int RUN_CW   = $clog2(MAX_RUNS + 1);

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_CLOSE  = 2'd1,
      ACT_LOOKUP = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   localparam logic [1:0] ST_DONE       = 2'd0;
   localparam logic [1:0] ST_STORE_FULL = 2'd1;
   localparam logic [1:0] ST_RUNS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN_LOAD,
      S_PROBE,
      S_COMPARE,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic [1:0]       action;
      logic [KEY_W-1:0] key_word;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [3:0]       run_index;
      logic [11:0]      position;
      logic [KEY_W-1:0] entry_word;
   } rsp_type;

endpackage

[hdl/sorted_run_stack_lookup_core.sv]
// Sorted run stack lookup: append, close run, lookup, clear over one entry store.
// Append, close and clear finish in the idle state that accepts them. A lookup searches
// each closed run in turn, oldest first, by binary search; each halving reads the
// entry store in S_PROBE and compares the registered word in S_COMPARE. A hit ends it.
// One transaction in work at a time; a finished result may wait in a second slot.
// Synchronous reset clears counts, mask and handshake state; the store is not swept.
module sorted_run_stack_lookup_core
   import srsl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [KEY_W-1:0] csr_data
);

   state_type        state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [RUN_CW-1:0] runs_ff, runs_in;
   logic [FILL_W-1:0] run_end_ff [MAX_RUNS];
   logic [KEY_W-1:0] mask_ff;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [RUN_CW-1:0] run_ff, run_in;
   logic [FILL_W-1:0] base_ff, base_in;
   logic [FILL_W-1:0] end_ff, end_in;
   logic [FILL_W-1:0] len_ff, len_in;
   logic [FILL_W-1:0] lo_ff, lo_in;
   logic [FILL_W-1:0] hi_ff, hi_in;
   logic [FILL_W-1:0] mid_ff, mid_in;
   logic [KEY_W-1:0] cand_ff, cand_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          pend_ff, pend_in;

   logic              re_we;
   logic              mem_we;
   logic              rd_en;
   logic [STORE_AW-1:0] rd_addr;
   logic [KEY_W-1:0]  rd_data;
   logic              fin;
   rsp_type           fin_res;
   logic              out_free;
   logic [FILL_W-1:0] run_end;
   logic [FILL_W-1:0] mid;
   logic [KEY_W-1:0]  keep;

   srsl_ram #(
      .ADDR_W (STORE_AW),
      .DATA_W (KEY_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (fill_ff[STORE_AW-1:0]),
      .wr_data (req_data.key_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign keep      = ~mask_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;
   assign run_end   = run_end_ff[run_ff[RUN_IW-1:0]];
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      runs_in      = runs_ff;
      key_in       = key_ff;
      run_in       = run_ff;
      base_in      = base_ff;
      end_in       = end_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      cand_in      = cand_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      pend_in      = pend_ff;
      re_we        = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      fin          = 1'b0;
      fin_res      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (action_type'(req_data.action))
                  ACT_APPEND: begin
                     fin = 1'b1;
                     if (fill_ff >= FILL_W'(STORE_DEPTH)) begin
                        fin_res.status = ST_STORE_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  ACT_CLOSE: begin
                     fin = 1'b1;
                     if (runs_ff >= RUN_CW'(MAX_RUNS)) begin
                        fin_res.status = ST_RUNS_FULL;
                     end else begin
                        re_we   = 1'b1;
                        runs_in = runs_ff + 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     fin     = 1'b1;
                     fill_in = '0;
                     runs_in = '0;
                  end
                  ACT_LOOKUP: begin
                     key_in   = req_data.key_word;
                     run_in   = '0;
                     base_in  = '0;
                     state_in = S_RUN_LOAD;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_RUN_LOAD: begin
            if (run_ff >= runs_ff) begin
               fin = 1'b1;
            end else begin
               end_in   = run_end;
               len_in   = (run_end > base_ff) ? run_end - base_ff : '0;
               lo_in    = '0;
               hi_in    = (run_end > base_ff) ? run_end - base_ff : '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               rd_en    = 1'b1;
               rd_addr  = STORE_AW'(base_ff + mid);
               state_in = S_COMPARE;
            end else if (lo_ff < len_ff && (cand_ff & keep) == key_ff) begin
               // cand holds the word last read with hi set to mid, i.e. entry at lo
               fin                = 1'b1;
               fin_res.found      = 1'b1;
               fin_res.run_index  = 4'(run_ff);
               fin_res.position   = 12'(lo_ff);
               fin_res.entry_word = cand_ff;
            end else begin
               if (end_ff > base_ff) begin
                  base_in = end_ff;
               end
               run_in   = run_ff + 1'b1;
               state_in = S_RUN_LOAD;
            end
         end
         S_COMPARE: begin
            if ((rd_data & keep) < key_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in   = mid_ff;
               cand_in = rd_data;
            end
            state_in = S_PROBE;
         end
         S_HOLD: begin
            if (out_free) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            out_in       = fin_res;
            out_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         runs_ff      <= '0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         runs_ff      <= runs_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      run_ff  <= run_in;
      base_ff <= base_in;
      end_ff  <= end_in;
      len_ff  <= len_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      cand_ff <= cand_in;
      out_ff  <= out_in;
      pend_ff <= pend_in;
      if (re_we) begin
         run_end_ff[runs_ff[RUN_IW-1:0]] <= fill_ff;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(STORE_DEPTH))
      else $error("fill count beyond store depth");

   a_runs_bound: assert property (@(posedge clock) disable iff (reset)
      runs_ff <= RUN_CW'(MAX_RUNS))
      else $error("run count beyond run limit");

   a_compare_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMPARE |-> $past(state_ff) == S_PROBE)
      else $error("compare without a preceding read");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> lo_ff <= hi_ff && hi_ff <= len_ff)
      else $error("binary search window inverted");

   a_hold_needs_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> out_valid_ff)
      else $error("pending result while output slot empty");

endmodule

[hdl/srsl_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module srsl_ram #(
   parameter int ADDR_W = 12,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for sorted_run_stack_lookup_core: appends, run closes, lookups
// and clears are checked against a behavioral copy of the run stack kept here.
// Depends on srsl_pkg and the core RTL.
module tb_top;
   import srsl_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 50;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_FIRST  = 60;
   localparam int HOLD_AT_SECOND = 500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 50;
   localparam int NUM_PHASES     = 7;
   localparam int FILL_RUN_LEN   = 16;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [KEY_W-1:0] csr_data  = '0;

   logic req_fire;
   logic rsp_fire;
   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // behavioral copy of the run stack
   logic [KEY_W-1:0] type_mask = '0;
   logic [KEY_W-1:0] store_mem [STORE_DEPTH];
   int unsigned      run_end [MAX_RUNS];
   int unsigned      run_cnt  = 0;
   int unsigned      fill_cnt = 0;

   req_type          req_queue [$];
   rsp_type          result_queue [$];
   rsp_type          want_rsp;
   int unsigned      req_issued  = 0;
   int unsigned      req_taken   = 0;
   int unsigned      rsp_taken   = 0;
   int unsigned      error_count = 0;

   // what the stimulus side believes is stored
   logic [KEY_W-1:0] known_hashlets [$];
   int unsigned      gen_runs = 0;

   int unsigned      req_gap      = 0;
   int unsigned      req_calm     = 0;
   int unsigned      stall_left   = 0;
   int unsigned      rsp_calm     = 0;
   int unsigned      quiet_cycles = 0;

   sorted_run_stack_lookup_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [KEY_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int unsigned idle_len(inout int unsigned calm);
      int unsigned pick;
      if (calm != 0) begin
         calm--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic rsp_type apply_request(req_type item);
      rsp_type          res;
      int unsigned      r, base, stop, span, lo, hi, mid;
      logic [KEY_W-1:0] keep;
      res        = '0;
      res.status = ST_DONE;
      keep       = ~type_mask;
      case (item.action)
         ACT_APPEND: begin
            if (fill_cnt >= STORE_DEPTH) begin
               res.status = ST_STORE_FULL;
            end else begin
               store_mem[fill_cnt] = item.key_word;
               fill_cnt++;
            end
         end
         ACT_CLOSE: begin
            if (run_cnt >= MAX_RUNS) begin
               res.status = ST_RUNS_FULL;
            end else begin
               run_end[run_cnt] = fill_cnt;
               run_cnt++;
            end
         end
         ACT_CLEAR: begin
            run_cnt  = 0;
            fill_cnt = 0;
         end
         ACT_LOOKUP: begin
            // lower-bound search per run, oldest run first; first exact hit wins
            base = 0;
            for (r = 0; r < run_cnt && !res.found; r++) begin
               stop = (run_end[r] > STORE_DEPTH) ? STORE_DEPTH : run_end[r];
               span = (stop > base) ? stop - base : 0;
               lo   = 0;
               hi   = span;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if ((store_mem[base + mid] & keep) < item.key_word) lo = mid + 1;
                  else hi = mid;
               end
               if (lo < span && (store_mem[base + lo] & keep) == item.key_word) begin
                  res.found      = 1'b1;
                  res.run_index  = 4'(r);
                  res.position   = 12'(lo);
                  res.entry_word = store_mem[base + lo];
               end
               if (stop > base) base = stop;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_fire) begin
            result_queue.push_back(apply_request(req_data));
            req_taken++;
            req_gap = idle_len(req_calm);
         end
         if (req_gap == 0 && req_queue.size() != 0) begin
            req_data  <= req_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
            if (req_gap != 0) req_gap--;
         end
      end
   end

   // monitor and result-side stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_taken++;
            if (result_queue.size() == 0) begin
               $error("result transaction with nothing expected");
               error_count++;
            end else begin
               want_rsp = result_queue.pop_front();
               if (rsp_data.status !== want_rsp.status) begin
                  $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.found !== want_rsp.found) begin
                  $error("found: expected %0d, got %0d", want_rsp.found, rsp_data.found);
                  error_count++;
               end
               if (rsp_data.run_index !== want_rsp.run_index) begin
                  $error("run_index: expected %0d, got %0d",
                         want_rsp.run_index, rsp_data.run_index);
                  error_count++;
               end
               if (rsp_data.position !== want_rsp.position) begin
                  $error("position: expected %0d, got %0d",
                         want_rsp.position, rsp_data.position);
                  error_count++;
               end
               if (rsp_data.entry_word !== want_rsp.entry_word) begin
                  $error("entry_word: expected %h, got %h",
                         want_rsp.entry_word, rsp_data.entry_word);
                  error_count++;
               end
            end
         end
         // long hold-off so the core backs up into its input
         if (rsp_fire && (rsp_taken == HOLD_AT_FIRST || rsp_taken == HOLD_AT_SECOND))
            stall_left = HOLD_CYCLES;
         else if (stall_left == 0 && (rsp_fire || $urandom_range(0, 7) == 0))
            stall_left = idle_len(rsp_calm);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_item(input action_type act, input logic [KEY_W-1:0] key);
      req_type item;
      item.action   = act;
      item.key_word = key;
      req_queue.push_back(item);
      req_issued++;
      case (act)
         ACT_CLOSE: if (gen_runs < MAX_RUNS) gen_runs++;
         ACT_CLEAR: begin
            gen_runs = 0;
            known_hashlets.delete();
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained(input int unsigned settle);
      do @(posedge clock);
      while (req_taken != req_issued || result_queue.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mask(input logic [KEY_W-1:0] value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      type_mask = value;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_hashlet();
      logic [KEY_W-1:0] h;
      int unsigned      sel;
      sel = $urandom_range(0, 99);
      if (sel >= 95) return rand64();
      if (known_hashlets.size() == 0 || sel >= 85) h = rand64() & ~type_mask;
      else h = known_hashlets[$urandom_range(0, known_hashlets.size() - 1)];
      if (sel >= 60 && sel < 70) h = h + 64'd1;
      else if (sel >= 70 && sel < 85) h = h | (rand64() & type_mask);
      return h;
   endfunction

   // one run of appends; ordered runs are sorted on the compared bits
   task automatic add_run(input int unsigned len, input bit ordered, input bit closing);
      logic [KEY_W-1:0] keep, top, x, stepv, key;
      int unsigned      pc, i, b, j;
      keep = ~type_mask;
      pc   = $countones(keep);
      top  = (pc == KEY_W) ? '1 : (64'd1 << pc) - 64'd1;
      case ($urandom_range(0, 2))
         0: x = 64'($urandom_range(0, 15)) & top;
         1: x = (rand64() >> $urandom_range(0, 63)) & top;
         default: x = (top > 64'(2 * len)) ? top - 64'($urandom_range(0, 2 * len)) : '0;
      endcase
      for (i = 0; i < len; i++) begin
         if (!ordered) x = rand64() & top;
         // scatter x into the compared bit positions, which keeps the order
         key = '0;
         j   = 0;
         for (b = 0; b < KEY_W; b++) begin
            if (keep[b]) begin
               key[b] = x[j];
               j++;
            end
         end
         known_hashlets.push_back(key);
         push_item(ACT_APPEND, key | (rand64() & type_mask));
         case ($urandom_range(0, 9))
            0, 1: stepv = '0;
            2, 3, 4, 5: stepv = 64'($urandom_range(1, 3));
            default: stepv = rand64() >> $urandom_range(4, 63);
         endcase
         x = (top - x < stepv) ? top : x + stepv;
      end
      if (closing) push_item(ACT_CLOSE, rand64());
   endtask

   task automatic random_phase(input int unsigned budget);
      int unsigned first, sel, len;
      first = req_issued;
      while (req_issued - first < budget) begin
         sel = $urandom_range(0, 99);
         if (gen_runs >= MAX_RUNS && sel < 70) begin
            push_item(ACT_CLEAR, rand64());
         end else if (sel < 50) begin
            case ($urandom_range(0, 19))
               0:       len = 0;
               1, 2, 3: len = $urandom_range(9, 40);
               4:       len = $urandom_range(60, 120);
               default: len = $urandom_range(1, 8);
            endcase
            add_run(len, $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
         end else if (sel < 85) begin
            repeat ($urandom_range(1, 4)) push_item(ACT_LOOKUP, pick_hashlet());
         end else if (sel < 90) begin
            push_item(ACT_CLEAR, rand64());
         end else begin
            push_item(action_type'($urandom_range(0, 3)), rand64());
         end
      end
   endtask

   initial begin
      logic [KEY_W-1:0] phase_masks [NUM_PHASES];
      int unsigned      ph;
      phase_masks = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFF00_0000_0000_0000,
                      64'h0000_0000_0000_000F, 64'h8000_0000_0000_0001, 64'h0, 64'h0};
      phase_masks[5] = rand64();
      phase_masks[6] = rand64() & rand64() & rand64();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty stack, empty run, open run is not searched
      push_item(ACT_LOOKUP, '0);
      push_item(ACT_CLOSE, '0);
      push_item(ACT_APPEND, '0);
      push_item(ACT_APPEND, 64'd5);
      push_item(ACT_APPEND, 64'd5);
      push_item(ACT_APPEND, '1);
      push_item(ACT_LOOKUP, 64'd5);
      push_item(ACT_CLOSE, '1);
      push_item(ACT_LOOKUP, '0);
      push_item(ACT_LOOKUP, 64'd5);
      push_item(ACT_LOOKUP, '1);
      push_item(ACT_LOOKUP, 64'd7);
      // same key in a later run: the older run is reported
      push_item(ACT_APPEND, 64'd5);
      push_item(ACT_CLOSE, '0);
      push_item(ACT_LOOKUP, 64'd5);
      // unsorted run
      push_item(ACT_APPEND, 64'd9);
      push_item(ACT_APPEND, 64'd3);
      push_item(ACT_CLOSE, '0);
      push_item(ACT_LOOKUP, 64'd3);
      push_item(ACT_LOOKUP, 64'd9);
      push_item(ACT_CLEAR, '1);
      push_item(ACT_LOOKUP, 64'd5);
      wait_drained(SETTLE_CYCLES);

      // type bits dropped from stored words, never from the hashlet
      write_mask(64'hF000_0000_0000_0000);
      push_item(ACT_APPEND, 64'h3000_0000_0000_0001);
      push_item(ACT_CLOSE, '0);
      push_item(ACT_LOOKUP, 64'h0000_0000_0000_0001);
      push_item(ACT_LOOKUP, 64'h1000_0000_0000_0001);
      wait_drained(SETTLE_CYCLES);

      // fill the run stack and overflow it; the extra appends stay in the open run
      push_item(ACT_CLEAR, '0);
      repeat (MAX_RUNS) add_run(FILL_RUN_LEN, 1'b1, 1'b1);
      repeat (3) push_item(ACT_APPEND, rand64());
      repeat (2) push_item(ACT_CLOSE, rand64());
      repeat (24) push_item(ACT_LOOKUP, pick_hashlet());
      wait_drained(SETTLE_CYCLES);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         write_mask(phase_masks[ph]);
         // one phase keeps the old runs, now compared under a new mask
         if (ph != 3) push_item(ACT_CLEAR, rand64());
         random_phase(PHASE_ITEMS);
         wait_drained(SETTLE_CYCLES);
      end

      wait_drained(END_CYCLES);
      if (result_queue.size() != 0) begin
         $error("%0d expected results never arrived", result_queue.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
